// ===== rtl/core/m64ieu_pkg.sv =====
// shared types, opcodes and result codes of the integer execute unit
package m64ieu_pkg;

    localparam int REG_COUNT = 32;
    localparam int REG_AW    = $clog2(REG_COUNT);
    localparam int XLEN      = 64;

    // major opcodes
    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_REGIMM  = 6'h01;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_BLEZ    = 6'h06;
    localparam logic [5:0] OP_BGTZ    = 6'h07;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTI    = 6'h0A;
    localparam logic [5:0] OP_SLTIU   = 6'h0B;
    localparam logic [5:0] OP_ANDI    = 6'h0C;
    localparam logic [5:0] OP_ORI     = 6'h0D;
    localparam logic [5:0] OP_XORI    = 6'h0E;
    localparam logic [5:0] OP_LUI     = 6'h0F;
    localparam logic [5:0] OP_BEQL    = 6'h14;
    localparam logic [5:0] OP_BNEL    = 6'h15;
    localparam logic [5:0] OP_BLEZL   = 6'h16;
    localparam logic [5:0] OP_BGTZL   = 6'h17;
    localparam logic [5:0] OP_DADDI   = 6'h18;
    localparam logic [5:0] OP_DADDIU  = 6'h19;

    // special function codes
    localparam logic [5:0] FN_SLL     = 6'h00;
    localparam logic [5:0] FN_SLLV    = 6'h04;
    localparam logic [5:0] FN_JR      = 6'h08;
    localparam logic [5:0] FN_JALR    = 6'h09;
    localparam logic [5:0] FN_MOVZ    = 6'h0A;
    localparam logic [5:0] FN_MOVN    = 6'h0B;
    localparam logic [5:0] FN_SYSCALL = 6'h0C;
    localparam logic [5:0] FN_BREAK   = 6'h0D;
    localparam logic [5:0] FN_MFHI    = 6'h10;
    localparam logic [5:0] FN_MTHI    = 6'h11;
    localparam logic [5:0] FN_MFLO    = 6'h12;
    localparam logic [5:0] FN_MTLO    = 6'h13;
    localparam logic [5:0] FN_DSLLV   = 6'h14;
    localparam logic [5:0] FN_DSRLV   = 6'h16;
    localparam logic [5:0] FN_DSRAV   = 6'h17;
    localparam logic [5:0] FN_MULT    = 6'h18;
    localparam logic [5:0] FN_MULTU   = 6'h19;
    localparam logic [5:0] FN_DIV     = 6'h1A;
    localparam logic [5:0] FN_DIVU    = 6'h1B;
    localparam logic [5:0] FN_ADD     = 6'h20;
    localparam logic [5:0] FN_ADDU    = 6'h21;
    localparam logic [5:0] FN_SUB     = 6'h22;
    localparam logic [5:0] FN_SUBU    = 6'h23;
    localparam logic [5:0] FN_AND     = 6'h24;
    localparam logic [5:0] FN_OR      = 6'h25;
    localparam logic [5:0] FN_XOR     = 6'h26;
    localparam logic [5:0] FN_NOR     = 6'h27;
    localparam logic [5:0] FN_SLT     = 6'h2A;
    localparam logic [5:0] FN_SLTU    = 6'h2B;
    localparam logic [5:0] FN_DADD    = 6'h2C;
    localparam logic [5:0] FN_DADDU   = 6'h2D;
    localparam logic [5:0] FN_DSUB    = 6'h2E;
    localparam logic [5:0] FN_DSUBU   = 6'h2F;
    localparam logic [5:0] FN_TGE     = 6'h30;
    localparam logic [5:0] FN_TGEU    = 6'h31;
    localparam logic [5:0] FN_TLT     = 6'h32;
    localparam logic [5:0] FN_TLTU    = 6'h33;
    localparam logic [5:0] FN_TEQ     = 6'h34;
    localparam logic [5:0] FN_TNE     = 6'h36;
    localparam logic [5:0] FN_DSLL    = 6'h38;
    localparam logic [5:0] FN_DSRL    = 6'h3A;
    localparam logic [5:0] FN_DSRA    = 6'h3B;
    localparam logic [5:0] FN_DSLL32  = 6'h3C;
    localparam logic [5:0] FN_DSRL32  = 6'h3E;
    localparam logic [5:0] FN_DSRA32  = 6'h3F;

    // regimm rt codes
    localparam logic [4:0] RI_TGEI    = 5'h08;
    localparam logic [4:0] RI_TGEIU   = 5'h09;
    localparam logic [4:0] RI_TLTI    = 5'h0A;
    localparam logic [4:0] RI_TLTIU   = 5'h0B;
    localparam logic [4:0] RI_TEQI    = 5'h0C;
    localparam logic [4:0] RI_TNEI    = 5'h0E;

    localparam logic [2:0] EXC_NONE    = 3'd0;
    localparam logic [2:0] EXC_OVF     = 3'd1;
    localparam logic [2:0] EXC_TRAP    = 3'd2;
    localparam logic [2:0] EXC_BREAK   = 3'd3;
    localparam logic [2:0] EXC_SYSCALL = 3'd4;
    localparam logic [2:0] EXC_RESV    = 3'd5;

    typedef enum logic [1:0] {
        UNIT_ALU = 2'd0,
        UNIT_MUL = 2'd1,
        UNIT_DIV = 2'd2
    } t_unit;

    typedef struct packed {
        logic [31:0] instr;
        logic [31:0] pc8;
        logic [31:0] br_target;
        logic [31:0] j_target;
        t_unit       unit;
        logic        resv;
    } t_item;

    typedef struct packed {
        logic [31:0]     next_address;
        logic            branch_taken;
        logic            skip_delay_slot;
        logic [2:0]      exception_kind;
        logic [19:0]     exception_code;
        logic            write_enable;
        logic [REG_AW-1:0] dest_register;
        logic [XLEN-1:0] dest_value;
    } t_res;

    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

endpackage

// ===== rtl/core/mips64_integer_execute_unit.sv =====
// Integer execute unit: one MIPS-III instruction per transfer, one result per transfer.
// Items are decoded on entry and held in a two-entry queue; the back end runs one
// item at a time. From queue head to result register, plain ALU, branch and jump
// work passes register file read, operand latch, execute and result hand-off;
// MULT/MULTU also pass the registered 33x33 product, and DIV/DIVU the radix-2
// divider that retires one quotient bit a cycle.
// The register file reads zero for any register not yet written since reset.
module mips64_integer_execute_unit import m64ieu_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] i_instruction,
    input  logic [31:0] i_instr_address,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_next_address,
    output logic        o_branch_taken,
    output logic        o_skip_delay_slot,
    output logic [2:0]  o_exception_kind,
    output logic [19:0] o_exception_code,
    output logic        o_write_enable,
    output logic [4:0]  o_dest_register,
    output logic [63:0] o_dest_value
);
    t_item  dec_item;
    t_item  q_head;
    t_qstat q_stat;
    logic   q_pop;
    t_res   res;

    m64ieu_front u_front (
        .i_instruction(i_instruction), .i_instr_address(i_instr_address), .o_item(dec_item)
    );

    m64ieu_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_item(dec_item),
        .i_pop(q_pop), .o_head(q_head), .o_stat(q_stat)
    );

    m64ieu_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_qstat(q_stat), .i_head(q_head),
        .o_qpop(q_pop), .i_pop(pop), .o_empty(empty), .o_res(res)
    );

    assign full              = q_stat.full;
    assign o_next_address    = res.next_address;
    assign o_branch_taken    = res.branch_taken;
    assign o_skip_delay_slot = res.skip_delay_slot;
    assign o_exception_kind  = res.exception_kind;
    assign o_exception_code  = res.exception_code;
    assign o_write_enable    = res.write_enable;
    assign o_dest_register   = res.dest_register;
    assign o_dest_value      = res.dest_value;
endmodule

// ===== rtl/core/m64ieu_ram.sv =====
// generic single write port ram with registered read
module m64ieu_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/m64ieu_front.sv =====
// front end: decodes an instruction word into a work item for the back end
module m64ieu_front import m64ieu_pkg::*; (
    input  logic [31:0] i_instruction,
    input  logic [31:0] i_instr_address,
    output t_item       o_item
);
    logic [5:0]  op;
    logic [5:0]  fn;
    logic [4:0]  rt;
    logic [31:0] pc4;
    logic        legal;

    assign op  = i_instruction[31:26];
    assign fn  = i_instruction[5:0];
    assign rt  = i_instruction[20:16];
    assign pc4 = i_instr_address + 32'd4;

    always_comb begin
        legal = 1'b0;
        case (op)
            OP_SPECIAL: begin
                case (fn)
                    FN_SLL, FN_SLLV, FN_JR, FN_JALR, FN_MOVZ, FN_MOVN, FN_SYSCALL,
                    FN_BREAK, FN_MFHI, FN_MTHI, FN_MFLO, FN_MTLO, FN_DSLLV, FN_DSRLV,
                    FN_DSRAV, FN_MULT, FN_MULTU, FN_DIV, FN_DIVU, FN_ADD, FN_ADDU,
                    FN_SUB, FN_SUBU, FN_AND, FN_OR, FN_XOR, FN_NOR, FN_SLT, FN_SLTU,
                    FN_DADD, FN_DADDU, FN_DSUB, FN_DSUBU, FN_TGE, FN_TGEU, FN_TLT,
                    FN_TLTU, FN_TEQ, FN_TNE, FN_DSLL, FN_DSRL, FN_DSRA, FN_DSLL32,
                    FN_DSRL32, FN_DSRA32: legal = 1'b1;
                    default: legal = 1'b0;
                endcase
            end
            OP_REGIMM: begin
                // branch forms have bits 3 and 2 clear
                legal = (rt[3:2] == 2'b00 && rt[4] == rt[4]) ||
                        rt == RI_TGEI || rt == RI_TGEIU || rt == RI_TLTI ||
                        rt == RI_TLTIU || rt == RI_TEQI || rt == RI_TNEI;
                if (rt[3]) begin
                    legal = (rt[4] == 1'b0) &&
                            (rt == RI_TGEI || rt == RI_TGEIU || rt == RI_TLTI ||
                             rt == RI_TLTIU || rt == RI_TEQI || rt == RI_TNEI);
                end else if (rt[2]) begin
                    legal = 1'b0;
                end
            end
            OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ, OP_ADDI, OP_ADDIU,
            OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI, OP_LUI, OP_BEQL, OP_BNEL,
            OP_BLEZL, OP_BGTZL, OP_DADDI, OP_DADDIU: legal = 1'b1;
            default: legal = 1'b0;
        endcase
    end

    always_comb begin
        o_item.instr     = i_instruction;
        o_item.pc8       = i_instr_address + 32'd8;
        o_item.br_target = pc4 + {{14{i_instruction[15]}}, i_instruction[15:0], 2'b00};
        o_item.j_target  = {pc4[31:28], i_instruction[25:0], 2'b00};
        o_item.resv      = !legal;
        o_item.unit      = UNIT_ALU;
        if (legal && op == OP_SPECIAL) begin
            if (fn == FN_MULT || fn == FN_MULTU) begin
                o_item.unit = UNIT_MUL;
            end else if (fn == FN_DIV || fn == FN_DIVU) begin
                o_item.unit = UNIT_DIV;
            end
        end
    end
endmodule

// ===== rtl/core/m64ieu_queue.sv =====
// two-entry queue between front and back end
module m64ieu_queue import m64ieu_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_item  i_item,
    input  logic   i_pop,
    output t_item  o_head,
    output t_qstat o_stat
);
    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       do_push;
    logic       do_pop;

    assign o_stat.empty = (r_cnt == 2'd0);
    assign o_stat.full  = (r_cnt == 2'd2);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end
endmodule

// ===== rtl/core/m64ieu_back.sv =====
// back end: register file, alu, multiplier, iterative divider and result register
module m64ieu_back import m64ieu_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_qstat i_qstat,
    input  t_item  i_head,
    output logic   o_qpop,
    input  logic   i_pop,
    output logic   o_empty,
    output t_res   o_res
);
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_READ = 7'b0000010,
        S_EXEC = 7'b0000100,
        S_MUL  = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_DIVF = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    t_item             r_item;
    logic [XLEN-1:0]   r_a, r_b, r_hi, r_lo;
    logic              r_aok, r_bok;
    logic [REG_COUNT-1:0] r_gvld;
    t_res              r_res, n_res;
    t_res              r_out;
    logic              r_out_vld;
    logic [63:0]       r_prod;
    logic [31:0]       r_dquo, r_dden, r_drem;
    logic [4:0]        r_dcnt;
    logic              r_dnegq, r_dnegr, r_dzero;

    logic [XLEN-1:0]   rd_a, rd_b;
    logic              rf_we;
    logic [REG_AW-1:0] rf_waddr;
    logic [XLEN-1:0]   rf_wdata;

    // register file, one copy per read port
    m64ieu_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_rf_a (
        .i_clk(i_clk), .i_we(rf_we), .i_waddr(rf_waddr), .i_wdata(rf_wdata),
        .i_raddr(i_head.instr[25:21]), .o_rdata(rd_a)
    );
    m64ieu_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_rf_b (
        .i_clk(i_clk), .i_we(rf_we), .i_waddr(rf_waddr), .i_wdata(rf_wdata),
        .i_raddr(i_head.instr[20:16]), .o_rdata(rd_b)
    );

    assign o_qpop = (r_state == S_IDLE) && !i_qstat.empty;

    // instruction fields
    logic [5:0]  op, fn;
    logic [4:0]  rt, rd, sa;
    logic [15:0] imm;
    logic [63:0] simm;
    logic [31:0] a32, b32, simm32;
    assign op     = r_item.instr[31:26];
    assign fn     = r_item.instr[5:0];
    assign rt     = r_item.instr[20:16];
    assign rd     = r_item.instr[15:11];
    assign sa     = r_item.instr[10:6];
    assign imm    = r_item.instr[15:0];
    assign simm   = {{48{imm[15]}}, imm};
    assign a32    = r_a[31:0];
    assign b32    = r_b[31:0];
    assign simm32 = simm[31:0];

    function automatic logic [63:0] sext32(input logic [31:0] x);
        sext32 = {{32{x[31]}}, x};
    endfunction

    logic [31:0] add32, sub32, addi32, sll32, sllv32;
    logic [63:0] add64, sub64, addi64;
    logic        ovf_add32, ovf_sub32, ovf_addi32, ovf_add64, ovf_sub64, ovf_addi64;
    logic        lt_ab, ltu_ab, lt_ai, ltu_ai, a_neg, a_zero;
    assign add32      = a32 + b32;
    assign sub32      = a32 - b32;
    assign addi32     = a32 + simm32;
    assign add64      = r_a + r_b;
    assign sub64      = r_a - r_b;
    assign addi64     = r_a + simm;
    assign ovf_add32  = (a32[31] ^ add32[31]) & (b32[31] ^ add32[31]);
    assign ovf_sub32  = (a32[31] ^ b32[31]) & (a32[31] ^ sub32[31]);
    assign ovf_addi32 = (a32[31] ^ addi32[31]) & (simm32[31] ^ addi32[31]);
    assign ovf_add64  = (r_a[63] ^ add64[63]) & (r_b[63] ^ add64[63]);
    assign ovf_sub64  = (r_a[63] ^ r_b[63]) & (r_a[63] ^ sub64[63]);
    assign ovf_addi64 = (r_a[63] ^ addi64[63]) & (simm[63] ^ addi64[63]);
    assign lt_ab      = $signed(r_a) < $signed(r_b);
    assign ltu_ab     = r_a < r_b;
    assign lt_ai      = $signed(r_a) < $signed(simm);
    assign ltu_ai     = r_a < simm;
    assign a_neg      = r_a[63];
    assign a_zero     = (r_a == 64'd0);
    assign sll32      = b32 << sa;
    assign sllv32     = b32 << a32[4:0];

    // alu and branch evaluation
    logic [2:0]  e_exc;
    logic        e_we, e_branch, e_cond, e_likely, e_hi_we, e_lo_we;
    logic [4:0]  e_dst;
    logic [63:0] e_val;
    logic [31:0] e_target;
    logic [63:0] link;
    assign link = {32'd0, r_item.pc8};

    always_comb begin
        e_exc = EXC_NONE; e_we = 1'b0; e_dst = 5'd0; e_val = 64'd0;
        e_branch = 1'b0; e_cond = 1'b0; e_likely = 1'b0;
        e_target = r_item.br_target; e_hi_we = 1'b0; e_lo_we = 1'b0;
        if (r_item.resv) begin
            e_exc = EXC_RESV;
        end else begin
            case (op)
                OP_SPECIAL: begin
                    e_dst = rd;
                    case (fn)
                        FN_SLL:     begin e_we = 1'b1; e_val = sext32(sll32); end
                        FN_SLLV:    begin e_we = 1'b1; e_val = sext32(sllv32); end
                        FN_JR:      begin e_branch = 1'b1; e_cond = 1'b1; e_target = a32; end
                        FN_JALR:    begin
                            e_branch = 1'b1; e_cond = 1'b1; e_target = a32;
                            e_we = 1'b1; e_val = link;
                        end
                        FN_MOVZ:    begin e_we = (r_b == 64'd0); e_val = r_a; end
                        FN_MOVN:    begin e_we = (r_b != 64'd0); e_val = r_a; end
                        FN_SYSCALL: e_exc = EXC_SYSCALL;
                        FN_BREAK:   e_exc = EXC_BREAK;
                        FN_MFHI:    begin e_we = 1'b1; e_val = r_hi; end
                        FN_MTHI:    e_hi_we = 1'b1;
                        FN_MFLO:    begin e_we = 1'b1; e_val = r_lo; end
                        FN_MTLO:    e_lo_we = 1'b1;
                        FN_DSLLV:   begin e_we = 1'b1; e_val = r_b << r_a[5:0]; end
                        FN_DSRLV:   begin e_we = 1'b1; e_val = r_b >> r_a[5:0]; end
                        FN_DSRAV:   begin
                            e_we = 1'b1; e_val = $unsigned($signed(r_b) >>> r_a[5:0]);
                        end
                        FN_ADD:     begin
                            if (ovf_add32) e_exc = EXC_OVF;
                            else begin e_we = 1'b1; e_val = sext32(add32); end
                        end
                        FN_ADDU:    begin e_we = 1'b1; e_val = sext32(add32); end
                        FN_SUB:     begin
                            if (ovf_sub32) e_exc = EXC_OVF;
                            else begin e_we = 1'b1; e_val = sext32(sub32); end
                        end
                        FN_SUBU:    begin e_we = 1'b1; e_val = sext32(sub32); end
                        FN_AND:     begin e_we = 1'b1; e_val = r_a & r_b; end
                        FN_OR:      begin e_we = 1'b1; e_val = r_a | r_b; end
                        FN_XOR:     begin e_we = 1'b1; e_val = r_a ^ r_b; end
                        FN_NOR:     begin e_we = 1'b1; e_val = ~(r_a | r_b); end
                        FN_SLT:     begin e_we = 1'b1; e_val = {63'd0, lt_ab}; end
                        FN_SLTU:    begin e_we = 1'b1; e_val = {63'd0, ltu_ab}; end
                        FN_DADD:    begin
                            if (ovf_add64) e_exc = EXC_OVF;
                            else begin e_we = 1'b1; e_val = add64; end
                        end
                        FN_DADDU:   begin e_we = 1'b1; e_val = add64; end
                        FN_DSUB:    begin
                            if (ovf_sub64) e_exc = EXC_OVF;
                            else begin e_we = 1'b1; e_val = sub64; end
                        end
                        FN_DSUBU:   begin e_we = 1'b1; e_val = sub64; end
                        FN_TGE:     if (!lt_ab) e_exc = EXC_TRAP;
                        FN_TGEU:    if (!ltu_ab) e_exc = EXC_TRAP;
                        FN_TLT:     if (lt_ab) e_exc = EXC_TRAP;
                        FN_TLTU:    if (ltu_ab) e_exc = EXC_TRAP;
                        FN_TEQ:     if (r_a == r_b) e_exc = EXC_TRAP;
                        FN_TNE:     if (r_a != r_b) e_exc = EXC_TRAP;
                        FN_DSLL:    begin e_we = 1'b1; e_val = r_b << sa; end
                        FN_DSRL:    begin e_we = 1'b1; e_val = r_b >> sa; end
                        FN_DSRA:    begin e_we = 1'b1; e_val = $unsigned($signed(r_b) >>> sa); end
                        FN_DSLL32:  begin e_we = 1'b1; e_val = r_b << {1'b1, sa}; end
                        FN_DSRL32:  begin e_we = 1'b1; e_val = r_b >> {1'b1, sa}; end
                        FN_DSRA32:  begin
                            e_we = 1'b1; e_val = $unsigned($signed(r_b) >>> {1'b1, sa});
                        end
                        default:    e_we = 1'b0; // multiply and divide finish later
                    endcase
                end
                OP_REGIMM: begin
                    if (!rt[3]) begin
                        // compare with zero, bit 1 likely, bit 4 link
                        e_branch = 1'b1;
                        e_cond   = rt[0] ? !a_neg : a_neg;
                        e_likely = rt[1];
                        e_we     = rt[4];
                        e_dst    = 5'd31;
                        e_val    = link;
                    end else begin
                        case (rt)
                            RI_TGEI:  if (!lt_ai) e_exc = EXC_TRAP;
                            RI_TGEIU: if (!ltu_ai) e_exc = EXC_TRAP;
                            RI_TLTI:  if (lt_ai) e_exc = EXC_TRAP;
                            RI_TLTIU: if (ltu_ai) e_exc = EXC_TRAP;
                            RI_TEQI:  if (r_a == simm) e_exc = EXC_TRAP;
                            RI_TNEI:  if (r_a != simm) e_exc = EXC_TRAP;
                            default:  e_exc = EXC_RESV;
                        endcase
                    end
                end
                OP_J, OP_JAL: begin
                    e_branch = 1'b1; e_cond = 1'b1; e_target = r_item.j_target;
                    e_we = op[0]; e_dst = 5'd31; e_val = link;
                end
                OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ, OP_BEQL, OP_BNEL, OP_BLEZL, OP_BGTZL: begin
                    e_branch = 1'b1; e_likely = op[4];
                    case (op[1:0])
                        2'd0:    e_cond = (r_a == r_b);
                        2'd1:    e_cond = (r_a != r_b);
                        2'd2:    e_cond = a_zero || a_neg;
                        default: e_cond = !a_zero && !a_neg;
                    endcase
                end
                OP_ADDI: begin
                    e_dst = rt;
                    if (ovf_addi32) e_exc = EXC_OVF;
                    else begin e_we = 1'b1; e_val = sext32(addi32); end
                end
                OP_ADDIU:  begin e_dst = rt; e_we = 1'b1; e_val = sext32(addi32); end
                OP_SLTI:   begin e_dst = rt; e_we = 1'b1; e_val = {63'd0, lt_ai}; end
                OP_SLTIU:  begin e_dst = rt; e_we = 1'b1; e_val = {63'd0, ltu_ai}; end
                OP_ANDI:   begin e_dst = rt; e_we = 1'b1; e_val = r_a & {48'd0, imm}; end
                OP_ORI:    begin e_dst = rt; e_we = 1'b1; e_val = r_a | {48'd0, imm}; end
                OP_XORI:   begin e_dst = rt; e_we = 1'b1; e_val = r_a ^ {48'd0, imm}; end
                OP_LUI:    begin e_dst = rt; e_we = 1'b1; e_val = sext32({imm, 16'd0}); end
                OP_DADDI: begin
                    e_dst = rt;
                    if (ovf_addi64) e_exc = EXC_OVF;
                    else begin e_we = 1'b1; e_val = addi64; end
                end
                OP_DADDIU: begin e_dst = rt; e_we = 1'b1; e_val = addi64; end
                default:   e_exc = EXC_RESV;
            endcase
        end
    end

    // fold exceptions, branch outcome and register zero into the result
    always_comb begin
        n_res.next_address    = r_item.pc8;
        n_res.branch_taken    = 1'b0;
        n_res.skip_delay_slot = 1'b0;
        n_res.exception_kind  = e_exc;
        n_res.exception_code  = 20'd0;
        n_res.write_enable    = e_we && (e_exc == EXC_NONE) && (e_dst != 5'd0);
        n_res.dest_register   = n_res.write_enable ? e_dst : 5'd0;
        n_res.dest_value      = n_res.write_enable ? e_val : 64'd0;
        if (e_exc == EXC_BREAK || e_exc == EXC_SYSCALL) begin
            n_res.exception_code = r_item.instr[25:6];
        end
        if (e_exc == EXC_NONE && e_branch) begin
            if (e_cond) begin
                n_res.branch_taken = 1'b1;
                n_res.next_address = e_target;
            end else if (e_likely) begin
                n_res.skip_delay_slot = 1'b1;
            end
        end
    end

    // multiplier operands, signed forms extend the sign bit
    logic               msigned;
    logic signed [32:0] ma, mb;
    logic signed [65:0] mp;
    assign msigned = (fn == FN_MULT);
    assign ma      = $signed({msigned & a32[31], a32});
    assign mb      = $signed({msigned & b32[31], b32});
    assign mp      = ma * mb;

    // divider step on magnitudes
    logic        dsigned;
    logic [32:0] drem_sh;
    logic        dge;
    logic [31:0] d_q, d_r;
    assign dsigned = (fn == FN_DIV);
    assign drem_sh = {r_drem, r_dquo[31]};
    assign dge     = drem_sh >= {1'b0, r_dden};
    assign d_q     = r_dnegq ? (32'd0 - r_dquo) : r_dquo;
    assign d_r     = r_dnegr ? (32'd0 - r_drem) : r_drem;

    // register file write port
    always_comb begin
        rf_we    = 1'b0;
        rf_waddr = r_res.dest_register;
        rf_wdata = r_res.dest_value;
        if (r_state == S_EXEC && r_item.unit == UNIT_ALU) begin
            rf_we    = n_res.write_enable;
            rf_waddr = n_res.dest_register;
            rf_wdata = n_res.dest_value;
        end else if (r_state == S_MUL) begin
            rf_we    = (rd != 5'd0);
            rf_waddr = rd;
            rf_wdata = sext32(r_prod[31:0]);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (!i_qstat.empty) n_state = S_READ;
            S_READ: n_state = S_EXEC;
            S_EXEC: begin
                case (r_item.unit)
                    UNIT_MUL: n_state = S_MUL;
                    UNIT_DIV: n_state = S_DIV;
                    default:  n_state = S_DONE;
                endcase
            end
            S_MUL:  n_state = S_DONE;
            S_DIV:  if (r_dcnt == 5'd31) n_state = S_DIVF;
            S_DIVF: n_state = S_DONE;
            S_DONE: if (!r_out_vld || i_pop) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_gvld    <= '0;
            r_hi      <= 64'd0;
            r_lo      <= 64'd0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (rf_we) begin
                r_gvld[rf_waddr] <= 1'b1;
            end
            if (r_state == S_EXEC && r_item.unit == UNIT_ALU) begin
                if (e_hi_we && e_exc == EXC_NONE) r_hi <= r_a;
                if (e_lo_we && e_exc == EXC_NONE) r_lo <= r_a;
            end
            if (r_state == S_MUL) begin
                r_lo <= sext32(r_prod[31:0]);
                r_hi <= sext32(r_prod[63:32]);
            end
            if (r_state == S_DIVF && !r_dzero) begin
                r_lo <= sext32(d_q);
                r_hi <= sext32(d_r);
            end
            if (r_state == S_DONE && (!r_out_vld || i_pop)) begin
                r_out_vld <= 1'b1;
            end else if (i_pop) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_item <= i_head;
                r_aok  <= (i_head.instr[25:21] != 5'd0) && r_gvld[i_head.instr[25:21]];
                r_bok  <= (i_head.instr[20:16] != 5'd0) && r_gvld[i_head.instr[20:16]];
            end
            S_READ: begin
                r_a <= r_aok ? rd_a : 64'd0;
                r_b <= r_bok ? rd_b : 64'd0;
            end
            S_EXEC: begin
                r_res  <= n_res;
                r_prod <= mp[63:0];
                r_dquo <= (dsigned && a32[31]) ? (32'd0 - a32) : a32;
                r_dden <= (dsigned && b32[31]) ? (32'd0 - b32) : b32;
                r_drem <= 32'd0;
                r_dcnt <= 5'd0;
                r_dnegq <= dsigned && (a32[31] ^ b32[31]);
                r_dnegr <= dsigned && a32[31];
                r_dzero <= (b32 == 32'd0);
            end
            S_MUL: begin
                r_res.write_enable  <= (rd != 5'd0);
                r_res.dest_register <= rd;
                r_res.dest_value    <= (rd != 5'd0) ? sext32(r_prod[31:0]) : 64'd0;
            end
            S_DIV: begin
                r_drem <= dge ? (drem_sh[31:0] - r_dden) : drem_sh[31:0];
                r_dquo <= {r_dquo[30:0], dge};
                r_dcnt <= r_dcnt + 5'd1;
            end
            S_DONE: begin
                if (!r_out_vld || i_pop) r_out <= r_res;
            end
            default: r_dcnt <= r_dcnt;
        endcase
    end

    assign o_empty = !r_out_vld;
    assign o_res   = r_out;

`ifndef SYNTHESIS
    a_no_zero_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rf_we |-> rf_waddr != 5'd0)
        else $error("write to register zero");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_qpop |=> r_state == S_READ)
        else $error("queue transfer outside idle");
    a_hilo_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_lo) |-> ($past(r_state) == S_EXEC || $past(r_state) == S_MUL ||
                            $past(r_state) == S_DIVF))
        else $error("lo changed outside a commit state");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_pop) |=> $stable(r_out))
        else $error("waiting result overwritten");
`endif
endmodule

// ===== verif/tb_top.sv =====
// testbench of the integer execute unit: directed table, then random instruction stream
`timescale 1ns / 100ps

module tb_top import m64ieu_pkg::*;;

    // regimm branch codes
    localparam logic [4:0] RI_BLTZ    = 5'h00;
    localparam logic [4:0] RI_BGEZ    = 5'h01;
    localparam logic [4:0] RI_BLTZL   = 5'h02;
    localparam logic [4:0] RI_BGEZL   = 5'h03;
    localparam logic [4:0] RI_BLTZAL  = 5'h10;
    localparam logic [4:0] RI_BGEZAL  = 5'h11;
    localparam logic [4:0] RI_BLTZALL = 5'h12;
    localparam logic [4:0] RI_BGEZALL = 5'h13;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam int RANDOM_ITEMS = 1650;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        pop = 1'b0;
    logic [31:0] i_instruction = '0;
    logic [31:0] i_instr_address = '0;
    logic        full, empty;
    logic [31:0] o_next_address;
    logic        o_branch_taken, o_skip_delay_slot, o_write_enable;
    logic [2:0]  o_exception_kind;
    logic [19:0] o_exception_code;
    logic [4:0]  o_dest_register;
    logic [63:0] o_dest_value;

    typedef struct {
        logic [31:0] ins;
        logic [31:0] addr;
        bit          fixed;
        t_res        res;
    } t_row;

    logic [63:0] gpr [REG_COUNT];
    logic [63:0] hi_q, lo_q;
    t_res        pending_q[$];
    t_row        rows[$];
    int          errors = 0;
    int          s_idle = 30;
    int          r_idle = 59;
    int          rcv_cycles = 0;

    logic [5:0] fn_list [41] = '{FN_SLL, FN_SLLV, FN_JR, FN_JALR, FN_MOVZ, FN_MOVN,
        FN_SYSCALL, FN_BREAK, FN_MFHI, FN_MTHI, FN_MFLO, FN_MTLO, FN_DSLLV, FN_DSRLV,
        FN_DSRAV, FN_MULT, FN_MULTU, FN_DIV, FN_DIVU, FN_ADD, FN_ADDU, FN_SUB, FN_SUBU,
        FN_AND, FN_OR, FN_XOR, FN_NOR, FN_SLT, FN_SLTU, FN_DADD, FN_DADDU, FN_DSUB,
        FN_DSUBU, FN_TGE, FN_TGEU, FN_TLT, FN_TLTU, FN_TEQ, FN_TNE, FN_DSLL, FN_DSRA32};
    logic [5:0] op_list [20] = '{OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ,
        OP_ADDI, OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI, OP_LUI,
        OP_BEQL, OP_BNEL, OP_BLEZL, OP_BGTZL, OP_DADDI, OP_DADDIU};
    logic [4:0] ri_list [14] = '{RI_BLTZ, RI_BGEZ, RI_BLTZL, RI_BGEZL, RI_BLTZAL,
        RI_BGEZAL, RI_BLTZALL, RI_BGEZALL, RI_TGEI, RI_TGEIU, RI_TLTI, RI_TLTIU,
        RI_TEQI, RI_TNEI};
    logic [5:0] shift_list [4] = '{FN_DSRL, FN_DSLL32, FN_DSRL32, FN_DSRA};

    mips64_integer_execute_unit u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_instruction     (i_instruction),
        .i_instr_address   (i_instr_address),
        .empty             (empty),
        .pop               (pop),
        .o_next_address    (o_next_address),
        .o_branch_taken    (o_branch_taken),
        .o_skip_delay_slot (o_skip_delay_slot),
        .o_exception_kind  (o_exception_kind),
        .o_exception_code  (o_exception_code),
        .o_write_enable    (o_write_enable),
        .o_dest_register   (o_dest_register),
        .o_dest_value      (o_dest_value)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [63:0] sx32(logic [31:0] x);
        return {{32{x[31]}}, x};
    endfunction

    function automatic logic [31:0] rtype(int rs, int rt, int rd, int sa, logic [5:0] fn);
        return {OP_SPECIAL, rs[4:0], rt[4:0], rd[4:0], sa[4:0], fn};
    endfunction

    function automatic logic [31:0] itype(logic [5:0] op, int rs, int rt, logic [15:0] imm);
        return {op, rs[4:0], rt[4:0], imm};
    endfunction

    // executes one instruction on the shadow state and returns its result
    function automatic t_res execute(logic [31:0] ins, logic [31:0] pc);
        logic [5:0]  op, fn;
        logic [4:0]  rs, rt, rd, sa, dst;
        logic [15:0] imm;
        logic [63:0] simm, a, b, val, r64, prod;
        logic [31:0] a32, b32, r32, nxt, target;
        logic [2:0]  exc;
        logic [19:0] code;
        logic        we, br, cond, lk;
        longint      n, d, q, m;
        t_res        res;
        op = ins[31:26]; rs = ins[25:21]; rt = ins[20:16]; rd = ins[15:11];
        sa = ins[10:6]; fn = ins[5:0]; imm = ins[15:0];
        simm = {{48{imm[15]}}, imm};
        a = (rs == 0) ? 64'd0 : gpr[rs];
        b = (rt == 0) ? 64'd0 : gpr[rt];
        a32 = a[31:0]; b32 = b[31:0];
        nxt = pc + 32'd8; target = '0; exc = EXC_NONE; code = '0;
        we = 1'b0; br = 1'b0; cond = 1'b0; lk = 1'b0; dst = '0; val = '0;
        case (op)
            OP_SPECIAL: begin
                we = 1'b1; dst = rd;
                case (fn)
                    FN_SLL:   val = sx32(b32 << sa);
                    FN_SLLV:  val = sx32(b32 << a32[4:0]);
                    FN_JR:    begin we = 1'b0; br = 1'b1; cond = 1'b1; target = a32; end
                    FN_JALR:  begin
                        br = 1'b1; cond = 1'b1; target = a32; val = {32'd0, pc + 32'd8};
                    end
                    FN_MOVZ:  begin we = (b == 0); val = a; end
                    FN_MOVN:  begin we = (b != 0); val = a; end
                    FN_SYSCALL: begin exc = EXC_SYSCALL; code = ins[25:6]; end
                    FN_BREAK: begin exc = EXC_BREAK; code = ins[25:6]; end
                    FN_MFHI:  val = hi_q;
                    FN_MTHI:  begin we = 1'b0; hi_q = a; end
                    FN_MFLO:  val = lo_q;
                    FN_MTLO:  begin we = 1'b0; lo_q = a; end
                    FN_DSLLV: val = b << a[5:0];
                    FN_DSRLV: val = b >> a[5:0];
                    FN_DSRAV: val = $signed(b) >>> a[5:0];
                    FN_MULT, FN_MULTU: begin
                        if (fn == FN_MULT)
                            prod = $signed(sx32(a32)) * $signed(sx32(b32));
                        else
                            prod = {32'd0, a32} * {32'd0, b32};
                        lo_q = sx32(prod[31:0]);
                        hi_q = sx32(prod[63:32]);
                        val = lo_q;
                    end
                    FN_DIV:   begin
                        we = 1'b0;
                        if (b32 != 0) begin
                            n = $signed(sx32(a32)); d = $signed(sx32(b32));
                            q = n / d; m = n % d;
                            lo_q = sx32(q[31:0]); hi_q = sx32(m[31:0]);
                        end
                    end
                    FN_DIVU:  begin
                        we = 1'b0;
                        if (b32 != 0) begin
                            lo_q = sx32(a32 / b32); hi_q = sx32(a32 % b32);
                        end
                    end
                    FN_ADD:   begin
                        r32 = a32 + b32; val = sx32(r32);
                        if (((a32 ^ r32) & (b32 ^ r32)) >> 31) exc = EXC_OVF;
                    end
                    FN_ADDU:  val = sx32(a32 + b32);
                    FN_SUB:   begin
                        r32 = a32 - b32; val = sx32(r32);
                        if (((a32 ^ b32) & (a32 ^ r32)) >> 31) exc = EXC_OVF;
                    end
                    FN_SUBU:  val = sx32(a32 - b32);
                    FN_AND:   val = a & b;
                    FN_OR:    val = a | b;
                    FN_XOR:   val = a ^ b;
                    FN_NOR:   val = ~(a | b);
                    FN_SLT:   val = ($signed(a) < $signed(b)) ? 64'd1 : 64'd0;
                    FN_SLTU:  val = (a < b) ? 64'd1 : 64'd0;
                    FN_DADD:  begin
                        r64 = a + b; val = r64;
                        if (((a ^ r64) & (b ^ r64)) >> 63) exc = EXC_OVF;
                    end
                    FN_DADDU: val = a + b;
                    FN_DSUB:  begin
                        r64 = a - b; val = r64;
                        if (((a ^ b) & (a ^ r64)) >> 63) exc = EXC_OVF;
                    end
                    FN_DSUBU: val = a - b;
                    // traps never write a register
                    FN_TGE:   begin we = 1'b0; if (!($signed(a) < $signed(b))) exc = EXC_TRAP; end
                    FN_TGEU:  begin we = 1'b0; if (a >= b) exc = EXC_TRAP; end
                    FN_TLT:   begin we = 1'b0; if ($signed(a) < $signed(b)) exc = EXC_TRAP; end
                    FN_TLTU:  begin we = 1'b0; if (a < b) exc = EXC_TRAP; end
                    FN_TEQ:   begin we = 1'b0; if (a == b) exc = EXC_TRAP; end
                    FN_TNE:   begin we = 1'b0; if (a != b) exc = EXC_TRAP; end
                    FN_DSLL:  val = b << sa;
                    FN_DSRL:  val = b >> sa;
                    FN_DSRA:  val = $signed(b) >>> sa;
                    FN_DSLL32: val = b << (32 + sa);
                    FN_DSRL32: val = b >> (32 + sa);
                    FN_DSRA32: val = $signed(b) >>> (32 + sa);
                    default:  exc = EXC_RESV;
                endcase
            end
            OP_REGIMM: begin
                target = pc + 32'd4 + (simm[31:0] << 2);
                case (rt)
                    RI_BLTZ, RI_BLTZL, RI_BLTZAL, RI_BLTZALL,
                    RI_BGEZ, RI_BGEZL, RI_BGEZAL, RI_BGEZALL: begin
                        br = 1'b1; lk = rt[1];
                        cond = rt[0] ? !a[63] : a[63];
                        if (rt[4]) begin
                            we = 1'b1; dst = 5'd31; val = {32'd0, pc + 32'd8};
                        end
                    end
                    RI_TGEI:  if (!($signed(a) < $signed(simm))) exc = EXC_TRAP;
                    RI_TGEIU: if (a >= simm) exc = EXC_TRAP;
                    RI_TLTI:  if ($signed(a) < $signed(simm)) exc = EXC_TRAP;
                    RI_TLTIU: if (a < simm) exc = EXC_TRAP;
                    RI_TEQI:  if (a == simm) exc = EXC_TRAP;
                    RI_TNEI:  if (a != simm) exc = EXC_TRAP;
                    default:  exc = EXC_RESV;
                endcase
            end
            OP_J, OP_JAL: begin
                br = 1'b1; cond = 1'b1;
                r32 = pc + 32'd4;
                target = {r32[31:28], ins[25:0], 2'b00};
                if (op == OP_JAL) begin
                    we = 1'b1; dst = 5'd31; val = {32'd0, pc + 32'd8};
                end
            end
            OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ, OP_BEQL, OP_BNEL, OP_BLEZL, OP_BGTZL: begin
                br = 1'b1; lk = op[4];
                target = pc + 32'd4 + (simm[31:0] << 2);
                case (op[1:0])
                    2'd0: cond = (a == b);
                    2'd1: cond = (a != b);
                    2'd2: cond = (a == 0) || a[63];
                    default: cond = (a != 0) && !a[63];
                endcase
            end
            OP_ADDI: begin
                r32 = a32 + simm[31:0]; we = 1'b1; dst = rt; val = sx32(r32);
                if (((a32 ^ r32) & (simm[31:0] ^ r32)) >> 31) exc = EXC_OVF;
            end
            OP_ADDIU: begin we = 1'b1; dst = rt; val = sx32(a32 + simm[31:0]); end
            OP_SLTI:  begin
                we = 1'b1; dst = rt; val = ($signed(a) < $signed(simm)) ? 64'd1 : 64'd0;
            end
            OP_SLTIU: begin we = 1'b1; dst = rt; val = (a < simm) ? 64'd1 : 64'd0; end
            OP_ANDI:  begin we = 1'b1; dst = rt; val = a & {48'd0, imm}; end
            OP_ORI:   begin we = 1'b1; dst = rt; val = a | {48'd0, imm}; end
            OP_XORI:  begin we = 1'b1; dst = rt; val = a ^ {48'd0, imm}; end
            OP_LUI:   begin we = 1'b1; dst = rt; val = sx32({imm, 16'd0}); end
            OP_DADDI: begin
                r64 = a + simm; we = 1'b1; dst = rt; val = r64;
                if (((a ^ r64) & (simm ^ r64)) >> 63) exc = EXC_OVF;
            end
            OP_DADDIU: begin we = 1'b1; dst = rt; val = a + simm; end
            default:  exc = EXC_RESV;
        endcase
        if (exc != EXC_NONE) begin
            we = 1'b0;
        end else if (br) begin
            if (cond) nxt = target;
        end
        if (!we || dst == 0) begin
            we = 1'b0; dst = '0; val = '0;
        end
        if (we) gpr[dst] = val;
        res.next_address    = nxt;
        res.branch_taken    = (exc == EXC_NONE) && br && cond;
        res.skip_delay_slot = (exc == EXC_NONE) && br && !cond && lk;
        res.exception_kind  = exc;
        res.exception_code  = code;
        res.write_enable    = we;
        res.dest_register   = dst;
        res.dest_value      = val;
        return res;
    endfunction

    function automatic int pick_reg();
        // mostly low registers so that results feed later operands
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 7);
    endfunction

    function automatic logic [31:0] random_instr();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 8)
            return $urandom();
        if (sel < 20)
            return itype(($urandom_range(0, 1) != 0) ? OP_LUI : OP_ORI, pick_reg(),
                         pick_reg(), 16'($urandom()));
        if (sel < 60)
            return rtype(pick_reg(), pick_reg(), pick_reg(), $urandom_range(0, 31),
                         ($urandom_range(0, 9) == 0) ? shift_list[$urandom_range(0, 3)]
                                                     : fn_list[$urandom_range(0, 40)]);
        if (sel < 72)
            return itype(OP_REGIMM, pick_reg(), ri_list[$urandom_range(0, 13)],
                         16'($urandom()));
        return itype(op_list[$urandom_range(0, 19)], pick_reg(), pick_reg(),
                     16'($urandom()));
    endfunction

    task automatic send(logic [31:0] ins, logic [31:0] addr, bit fixed, t_res res);
        t_res predicted;
        while ($urandom_range(0, 99) < s_idle) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push            <= 1'b1;
        i_instruction   <= ins;
        i_instr_address <= addr;
        do @(posedge i_clk); while (full);
        predicted = execute(ins, addr);
        pending_q.push_back(fixed ? res : predicted);
    endtask

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        rcv_cycles++;
        // one long hold-off so the queue fills and pushes back
        if (rcv_cycles >= 3000 && rcv_cycles < 3400)
            pop <= 1'b0;
        else
            pop <= ($urandom_range(0, 99) >= r_idle);
    end

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && pop && !empty) begin
            if (pending_q.size() == 0) begin
                $error("result transfer with nothing expected");
                errors++;
            end else begin
                want = pending_q.pop_front();
                check_field("next_address", want.next_address, o_next_address);
                check_field("branch_taken", want.branch_taken, o_branch_taken);
                check_field("skip_delay_slot", want.skip_delay_slot, o_skip_delay_slot);
                check_field("exception_kind", want.exception_kind, o_exception_kind);
                check_field("exception_code", want.exception_code, o_exception_code);
                check_field("write_enable", want.write_enable, o_write_enable);
                check_field("dest_register", want.dest_register, o_dest_register);
                check_field("dest_value", want.dest_value, o_dest_value);
            end
        end
    end

    initial begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int wait_cycles;
        for (int i = 0; i < REG_COUNT; i++) gpr[i] = '0;
        hi_q = '0;
        lo_q = '0;

        // fixed expectations first, then rows left to the predictor
        rows.push_back('{rtype(0, 0, 1, 0, FN_MFHI), 32'h0000_1000, 1'b1,
                         '{32'h0000_1008, 1'b0, 1'b0, EXC_NONE, 20'h0, 1'b1, 5'd1, 64'h0}});
        rows.push_back('{32'h03FF_FFC0 | FN_BREAK, 32'hFFFF_FFFC, 1'b1,
                         '{32'h0000_0004, 1'b0, 1'b0, EXC_BREAK, 20'hFFFFF, 1'b0, 5'd0, 64'h0}});
        rows.push_back('{rtype(0, 0, 0, 0, FN_SYSCALL), 32'h0, 1'b1,
                         '{32'h0000_0008, 1'b0, 1'b0, EXC_SYSCALL, 20'h0, 1'b0, 5'd0, 64'h0}});
        rows.push_back('{itype(OP_LW, 31, 31, 16'hFFFF), 32'h8000_0000, 1'b1,
                         '{32'h8000_0008, 1'b0, 1'b0, EXC_RESV, 20'h0, 1'b0, 5'd0, 64'h0}});
        rows.push_back('{itype(OP_LUI, 0, 2, 16'h8000), 32'h100, 1'b1,
                         '{32'h108, 1'b0, 1'b0, EXC_NONE, 20'h0, 1'b1, 5'd2, 64'hFFFF_FFFF_8000_0000}});
        rows.push_back('{itype(OP_LUI, 0, 4, 16'h7FFF), 32'h0, 1'b0, '0});
        rows.push_back('{itype(OP_ORI, 4, 4, 16'hFFFF), 32'h0, 1'b0, '0});
        rows.push_back('{itype(OP_ADDIU, 0, 3, 16'hFFFF), 32'h0, 1'b0, '0});
        rows.push_back('{rtype(4, 4, 5, 0, FN_ADD), 32'h0, 1'b0, '0});
        rows.push_back('{rtype(2, 4, 5, 0, FN_SUB), 32'h0, 1'b0, '0});
        rows.push_back('{rtype(2, 2, 6, 0, FN_DADD), 32'h0, 1'b0, '0});
        rows.push_back('{rtype(2, 3, 7, 0, FN_MULT), 32'h0, 1'b0, '0});
        rows.push_back('{rtype(3, 3, 8, 0, FN_MULTU), 32'h0, 1'b0, '0});
        rows.push_back('{rtype(2, 3, 0, 0, FN_DIV), 32'h0, 1'b0, '0});
        rows.push_back('{rtype(4, 0, 0, 0, FN_DIVU), 32'h0, 1'b0, '0});
        rows.push_back('{rtype(0, 0, 9, 0, FN_MFLO), 32'h0, 1'b0, '0});
        rows.push_back('{rtype(0, 3, 10, 31, FN_DSRA32), 32'h0, 1'b0, '0});
        rows.push_back('{rtype(3, 4, 11, 0, FN_DSLLV), 32'h0, 1'b0, '0});
        rows.push_back('{itype(OP_BNEL, 0, 0, 16'h8000), 32'h2000, 1'b0, '0});
        rows.push_back('{itype(OP_REGIMM, 2, RI_BLTZAL, 16'h7FFF), 32'hFFFF_FFF8, 1'b0, '0});
        rows.push_back('{itype(OP_JAL, 31, 31, 16'hFFFF), 32'hEFFF_FFFC, 1'b0, '0});
        rows.push_back('{rtype(31, 0, 0, 0, FN_JALR), 32'h40, 1'b0, '0});
        rows.push_back('{rtype(3, 3, 0, 0, FN_TEQ), 32'h0, 1'b0, '0});
        rows.push_back('{itype(OP_ADDI, 4, 0, 16'h0001), 32'h0, 1'b0, '0});
        rows.push_back('{rtype(3, 0, 12, 0, FN_MOVZ), 32'h0, 1'b0, '0});

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[i])
            send(rows[i].ins, rows[i].addr, rows[i].fixed, rows[i].res);

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == RANDOM_ITEMS / 3) begin
                s_idle = 59; r_idle = 30;
            end else if (k == 2 * RANDOM_ITEMS / 3) begin
                s_idle = 0; r_idle = 0;
            end
            send(random_instr(), $urandom(), 1'b0, '0);
        end
        push <= 1'b0;

        wait_cycles = 0;
        while (pending_q.size() != 0 && wait_cycles < 100_000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (60) @(posedge i_clk);
        if (pending_q.size() != 0) begin
            $error("%0d results never arrived", pending_q.size());
            errors++;
        end
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/m64ieu_pkg.sv
rtl/core/m64ieu_ram.sv
rtl/core/m64ieu_front.sv
rtl/core/m64ieu_queue.sv
rtl/core/m64ieu_back.sv
rtl/core/mips64_integer_execute_unit.sv
verif/tb_top.sv
